@@ rtl/core/hsfp_pkg.sv @@
// shared constants, types and helper functions of the five-point heat stencil
package hsfp_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int BUF_DEPTH = MAX_COLS + 2;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int DIM_W     = 9;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + 1;
    localparam int QUOT_W    = DATA_W - 1;
    localparam int ACC_W     = 48;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int S_DATA_W  = 2 * DATA_W;
    localparam int M_DATA_W  = DATA_W + ACC_W;

    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(256);
    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(256);

    // register index, taken from paddr[2]
    localparam logic REG_GRID_COLS = 1'b0;
    localparam logic REG_GRID_ROWS = 1'b1;

    // what one accepted item asks of the arithmetic pipe
    typedef struct packed {
        logic result;
        logic clear;
        logic last;
    } hsfp_tok_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (raw == '0) begin
            res = DIM_W'(1);
        end else if (raw > hi) begin
            res = hi;
        end else begin
            res = raw;
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] sat_data(input logic [DATA_W:0] x);
        logic [DATA_W-1:0] res;
        if (x[DATA_W] != x[DATA_W-1]) begin
            res = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] x);
        logic [ACC_W-1:0] res;
        if (x[ACC_W] != x[ACC_W-1]) begin
            res = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = x[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/hsfp_cell.sv @@
// one window cell: holds a row value and hands it on to its neighbor
module hsfp_cell (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        sel_load,
    input  logic [hsfp_pkg::DATA_W-1:0] load_data,
    input  logic [hsfp_pkg::DATA_W-1:0] nbr_data,
    output logic [hsfp_pkg::DATA_W-1:0] d_out,
    output logic [hsfp_pkg::DATA_W-1:0] q
);

    logic [hsfp_pkg::DATA_W-1:0] q_reg;

    assign d_out = sel_load ? load_data : nbr_data;
    assign q     = q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= d_out;
        end
    end

endmodule

@@ rtl/core/hsfp_line_buf.sv @@
// two row line buffers, indexed by column, with registered reads
module hsfp_line_buf (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [hsfp_pkg::BUF_AW-1:0] wr_addr,
    input  logic [hsfp_pkg::DATA_W-1:0] wr_prev,
    input  logic [hsfp_pkg::DATA_W-1:0] wr_prev2,
    input  logic [hsfp_pkg::BUF_AW-1:0] rd_addr,
    output logic [hsfp_pkg::DATA_W-1:0] rd_prev_a,
    output logic [hsfp_pkg::DATA_W-1:0] rd_prev_b,
    output logic [hsfp_pkg::DATA_W-1:0] rd_prev2
);

    logic [hsfp_pkg::DATA_W-1:0] prev_mem  [hsfp_pkg::BUF_DEPTH];
    logic [hsfp_pkg::DATA_W-1:0] prev2_mem [hsfp_pkg::BUF_DEPTH];

    logic [hsfp_pkg::DATA_W-1:0] rd_prev_a_reg;
    logic [hsfp_pkg::DATA_W-1:0] rd_prev_b_reg;
    logic [hsfp_pkg::DATA_W-1:0] rd_prev2_reg;
    logic [hsfp_pkg::BUF_AW-1:0] rd_addr_b;

    // the top entry has no east neighbor; its read is never used
    assign rd_addr_b = (rd_addr == hsfp_pkg::BUF_AW'(hsfp_pkg::BUF_DEPTH - 1)) ?
                       rd_addr : rd_addr + 1'b1;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prev_mem[wr_addr]  <= wr_prev;
            prev2_mem[wr_addr] <= wr_prev2;
        end
    end

    always_ff @(posedge aclk) begin
        rd_prev_a_reg <= prev_mem[rd_addr];
        rd_prev_b_reg <= prev_mem[rd_addr_b];
        rd_prev2_reg  <= prev2_mem[rd_addr];
    end

    assign rd_prev_a = rd_prev_a_reg;
    assign rd_prev_b = rd_prev_b_reg;
    assign rd_prev2  = rd_prev2_reg;

endmodule

@@ rtl/core/hsfp_calc_pipe.sv @@
// stencil arithmetic pipe, heat accumulator and output register
module hsfp_calc_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  hsfp_pkg::hsfp_tok_t           in_tok,
    input  logic [hsfp_pkg::DATA_W-1:0]   north,
    input  logic [hsfp_pkg::DATA_W-1:0]   south,
    input  logic [hsfp_pkg::DATA_W-1:0]   west,
    input  logic [hsfp_pkg::DATA_W-1:0]   east,
    input  logic [hsfp_pkg::DATA_W-1:0]   prior,
    output logic                          in_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hsfp_pkg::DATA_W-1:0]   m_new_value,
    output logic [hsfp_pkg::ACC_W-1:0]    m_heat_total,
    output logic                          m_last
);

    localparam int DW  = hsfp_pkg::DATA_W;
    localparam int SW  = hsfp_pkg::SUM_W;
    localparam int QW  = hsfp_pkg::QUOT_W;
    localparam int AW  = hsfp_pkg::ACC_W;

    logic                v1_reg, v2_reg, v3_reg;
    hsfp_pkg::hsfp_tok_t tok1_reg, tok2_reg, tok3_reg;
    logic [SW-1:0]       ns1_reg, we1_reg;
    logic [DW-1:0]       half1_reg, half2_reg;
    logic [QW-1:0]       quot2_reg;
    logic [DW-1:0]       val3_reg;

    logic                m_valid_reg;
    logic [DW-1:0]       m_new_reg;
    logic [AW-1:0]       m_heat_reg;
    logic                m_last_reg;
    logic [AW-1:0]       acc_reg;

    logic                out_free, drain3, ld1, ld2, ld3;
    logic [SW:0]         sum4;
    logic [DW:0]         val_sum;
    logic [AW:0]         acc_sum;
    logic [AW-1:0]       acc_next;

    // a clear token never occupies the output register
    assign out_free = !m_valid_reg || m_ready;
    assign drain3   = v3_reg && (tok3_reg.clear || out_free);
    assign ld3      = !v3_reg || drain3;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    assign sum4     = {ns1_reg[SW-1], ns1_reg} + {we1_reg[SW-1], we1_reg};
    assign val_sum  = {half2_reg[DW-1], half2_reg} + {{2{quot2_reg[QW-1]}}, quot2_reg};
    assign acc_sum  = {acc_reg[AW-1], acc_reg} + {{(AW+1-DW){val3_reg[DW-1]}}, val3_reg};
    assign acc_next = hsfp_pkg::sat_acc(acc_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end else begin
            if (ld1) begin
                v1_reg <= in_valid;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
            if (ld3) begin
                v3_reg <= v2_reg;
            end
            if (drain3 && tok3_reg.result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (drain3 && tok3_reg.clear) begin
                acc_reg <= '0;
            end else if (drain3 && tok3_reg.result) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            tok1_reg  <= in_tok;
            ns1_reg   <= {north[DW-1], north} + {south[DW-1], south};
            we1_reg   <= {west[DW-1], west} + {east[DW-1], east};
            half1_reg <= {prior[DW-1], prior[DW-1:1]};
        end
        if (ld2) begin
            tok2_reg  <= tok1_reg;
            quot2_reg <= sum4[SW:3];
            half2_reg <= half1_reg;
        end
        if (ld3) begin
            tok3_reg  <= tok2_reg;
            val3_reg  <= hsfp_pkg::sat_data(val_sum);
        end
        if (drain3 && tok3_reg.result) begin
            m_new_reg  <= val3_reg;
            m_heat_reg <= tok3_reg.last ? acc_next : '0;
            m_last_reg <= tok3_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_new_value  = m_new_reg;
    assign m_heat_total = m_heat_reg;
    assign m_last       = m_last_reg;

    a_tok_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> !(tok1_reg.result && tok1_reg.clear))
        else $error("token asks for a result and a clear at once");

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain3 && tok3_reg.clear) |=> (acc_reg == '0))
        else $error("heat total not cleared at end of grid");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !ld1 |-> (v1_reg && v2_reg && v3_reg && m_valid_reg))
        else $error("input stalled while the pipe has room");

    a_heat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_heat_reg == '0))
        else $error("heat total shown on a result that is not last");

endmodule

@@ rtl/core/heat_stencil_five_point_unit.sv @@
// top level of the five-point heat stencil: position tracking, config, buffers, window
//
// usage:
//   s_ channel: one transfer per cell of the padded grid (halo ring included) in raster
//   order, (grid_rows + 2) rows of (grid_cols + 2) cells. tdata holds old_value and the
//   earlier new value of the interior cell one row above.
//   m_ channel: one transfer per interior cell once its window is complete, carrying the
//   new value; the transfer for the final interior cell raises tlast and carries the
//   saturated heat total of the grid, which then starts again from zero.
//   apb port: grid_cols at 0x0, grid_rows at 0x4; write only between items.
// throughput: one item per cycle unless stalled, set by the line buffers (one write port,
//   registered reads addressed one item ahead) and the three-stage arithmetic pipe.
// path: each result passes the three pipe stages, then the output register.
// reset: grid position and heat total clear, both dimensions return to 256; the line
//   buffers are not cleared, they are filled by the first two padded rows.
// stall: when m_tready is low, results queue in the pipe stages; s_tready drops only
//   once every stage and the output register hold data.
module heat_stencil_five_point_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] old_value, [63:32] prior_new
    input  logic [hsfp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] new_value, [79:32] heat_total
    output logic [hsfp_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsfp_pkg::PADDR_W-1:0]    paddr,
    input  logic [hsfp_pkg::PDATA_W-1:0]    pwdata,
    output logic [hsfp_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int DW = hsfp_pkg::DATA_W;
    localparam int NW = hsfp_pkg::DIM_W;

    logic [NW-1:0]          cfg_cols_reg, cfg_rows_reg;
    logic [NW-1:0]          col_reg, row_reg, col_next, row_next;
    logic [NW-1:0]          cols, rows;
    logic                   cfg_wr, accept, produce, wrap_col, last_row;
    hsfp_pkg::hsfp_tok_t    tok;
    logic [DW-1:0]          old_value, prior_new;
    logic [DW-1:0]          rd_prev_a, rd_prev_b, rd_prev2;
    logic [DW-1:0]          east_q, east_d, west_q, center;
    logic [hsfp_pkg::BUF_AW-1:0] rd_addr;
    logic [DW-1:0]          new_value;
    logic [hsfp_pkg::ACC_W-1:0] heat_total;
    logic                   col_zero;

    assign old_value = s_tdata[DW-1:0];
    assign prior_new = s_tdata[2*DW-1:DW];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg <= hsfp_pkg::COLS_RESET;
            cfg_rows_reg <= hsfp_pkg::ROWS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                hsfp_pkg::REG_GRID_COLS: cfg_cols_reg <= pwdata[NW-1:0];
                hsfp_pkg::REG_GRID_ROWS: cfg_rows_reg <= pwdata[NW-1:0];
                default:                 cfg_cols_reg <= cfg_cols_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hsfp_pkg::REG_GRID_COLS: prdata = hsfp_pkg::PDATA_W'(cfg_cols_reg);
            hsfp_pkg::REG_GRID_ROWS: prdata = hsfp_pkg::PDATA_W'(cfg_rows_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cols = hsfp_pkg::clamp_dim(cfg_cols_reg, NW'(hsfp_pkg::MAX_COLS));
    assign rows = hsfp_pkg::clamp_dim(cfg_rows_reg, NW'(hsfp_pkg::MAX_ROWS));

    // raster position over the padded grid
    assign accept   = s_tvalid && s_tready;
    assign produce  = (row_reg >= NW'(2)) && (row_reg <= rows + 1'b1) &&
                      (col_reg >= NW'(1)) && (col_reg <= cols);
    assign wrap_col = col_reg >= cols + 1'b1;
    assign last_row = row_reg >= rows + 1'b1;
    assign col_zero = col_reg == '0;

    always_comb begin
        if (wrap_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign tok.result = produce;
    assign tok.clear  = wrap_col && last_row;
    assign tok.last   = (row_reg == rows + 1'b1) && (col_reg == cols);

    // reads run one item ahead so back-to-back transfers find their data ready
    assign rd_addr = accept ? hsfp_pkg::BUF_AW'(col_next) : hsfp_pkg::BUF_AW'(col_reg);

    hsfp_line_buf u_line_buf (
        .aclk      (aclk),
        .wr_en     (accept),
        .wr_addr   (hsfp_pkg::BUF_AW'(col_reg)),
        .wr_prev   (old_value),
        .wr_prev2  (center),
        .rd_addr   (rd_addr),
        .rd_prev_a (rd_prev_a),
        .rd_prev_b (rd_prev_b),
        .rd_prev2  (rd_prev2)
    );

    // window cells on the row above: east holds column c+1, west the column before
    hsfp_cell u_cell_east (
        .aclk      (aclk),
        .en        (accept),
        .sel_load  (1'b0),
        .load_data (rd_prev_a),
        .nbr_data  (rd_prev_b),
        .d_out     (east_d),
        .q         (east_q)
    );

    // at the start of a row the chain holds nothing useful, so load from the buffer
    hsfp_cell u_cell_west (
        .aclk      (aclk),
        .en        (accept),
        .sel_load  (col_zero),
        .load_data (rd_prev_a),
        .nbr_data  (east_q),
        .d_out     (center),
        .q         (west_q)
    );

    hsfp_calc_pipe u_calc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (accept && (tok.result || tok.clear)),
        .in_tok       (tok),
        .north        (rd_prev2),
        .south        (old_value),
        .west         (west_q),
        .east         (east_d),
        .prior        (prior_new),
        .in_ready     (s_tready),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_new_value  (new_value),
        .m_heat_total (heat_total),
        .m_last       (m_tlast)
    );

    assign m_tdata = {heat_total, new_value};

endmodule

@@ dv/heat_stencil_checker.sv @@
`timescale 1ns / 1ps
// checker for the five-point heat stencil: predicts every cell update and compares results
module heat_stencil_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [31:0] old_value, [63:32] prior_new
    input  logic [hsfp_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] new_value, [79:32] heat_total
    input  logic [hsfp_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsfp_pkg::PADDR_W-1:0]    paddr,
    input  logic [hsfp_pkg::PDATA_W-1:0]    pwdata,
    input  logic                            pready,
    input  logic                            end_of_run,
    output int                              fail_count,
    output int                              pending,
    output int                              results_checked
);
    import hsfp_pkg::*;

    localparam int     REPORT_LIMIT = 20;
    localparam longint NEW_MAX      = 64'sd2147483647;
    localparam longint NEW_MIN      = -64'sd2147483648;
    localparam longint HEAT_MAX     = (64'sd1 <<< 47) - 64'sd1;
    localparam longint HEAT_MIN     = -(64'sd1 <<< 47);

    typedef struct {
        logic [DATA_W-1:0] new_value;
        logic [ACC_W-1:0]  heat_total;
        logic              last;
    } cell_result_t;

    cell_result_t      expected_cells [$];
    logic [DATA_W-1:0] row_above  [BUF_DEPTH];
    logic [DATA_W-1:0] row_above2 [BUF_DEPTH];
    int                cur_col;
    int                cur_row;
    longint            heat_sum;
    logic [DIM_W-1:0]  cols_raw;
    logic [DIM_W-1:0]  rows_raw;
    int                errors = 0;
    int                checked = 0;
    bit                leftover_done = 1'b0;

    function automatic int eff_dim(input logic [DIM_W-1:0] raw, input int hi);
        if (raw == '0) begin
            return 1;
        end
        return (int'(raw) > hi) ? hi : int'(raw);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic take_cell(input logic [DATA_W-1:0] old_v, input logic [DATA_W-1:0] prior_v);
        int           cols;
        int           rows;
        longint       neigh;
        longint       val;
        cell_result_t res;
        cols = eff_dim(cols_raw, MAX_COLS);
        rows = eff_dim(rows_raw, MAX_ROWS);
        if (cur_row >= 2 && cur_row <= rows + 1 && cur_col >= 1 && cur_col <= cols) begin
            // west already moved into the older line by the previous cell
            neigh = longint'($signed(row_above2[cur_col]))
                  + longint'($signed(row_above2[cur_col-1]))
                  + longint'($signed(row_above[cur_col+1]))
                  + longint'($signed(old_v));
            val = (longint'($signed(prior_v)) >>> 1) + (neigh >>> 3);
            if (val > NEW_MAX) begin
                val = NEW_MAX;
            end else if (val < NEW_MIN) begin
                val = NEW_MIN;
            end
            heat_sum += val;
            if (heat_sum > HEAT_MAX) begin
                heat_sum = HEAT_MAX;
            end else if (heat_sum < HEAT_MIN) begin
                heat_sum = HEAT_MIN;
            end
            res.new_value  = val[DATA_W-1:0];
            res.last       = (cur_row == rows + 1) && (cur_col == cols);
            res.heat_total = res.last ? heat_sum[ACC_W-1:0] : '0;
            expected_cells.push_back(res);
        end
        if (cur_col < BUF_DEPTH) begin
            row_above2[cur_col] = row_above[cur_col];
            row_above[cur_col]  = old_v;
        end
        if (cur_col >= cols + 1) begin
            cur_col = 0;
            if (cur_row >= rows + 1) begin
                cur_row  = 0;
                heat_sum = 0;
            end else begin
                cur_row++;
            end
        end else begin
            cur_col++;
        end
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] data, input logic last);
        cell_result_t      want;
        logic [DATA_W-1:0] got_new;
        logic [ACC_W-1:0]  got_total;
        got_new   = data[DATA_W-1:0];
        got_total = data[DATA_W +: ACC_W];
        checked++;
        if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d: new %h total %h last %b",
                                      checked, got_new, got_total, last));
            return;
        end
        want = expected_cells.pop_front();
        if (got_new !== want.new_value) begin
            report_mismatch($sformatf("result %0d new_value %h, want %h",
                                      checked, got_new, want.new_value));
        end
        if (got_total !== want.heat_total) begin
            report_mismatch($sformatf("result %0d heat_total %h, want %h",
                                      checked, got_total, want.heat_total));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("result %0d last %b, want %b", checked, last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_cells.delete();
            cur_col  = 0;
            cur_row  = 0;
            heat_sum = 0;
            cols_raw = COLS_RESET;
            rows_raw = ROWS_RESET;
            foreach (row_above[i]) begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tlast);
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_GRID_COLS) begin
                    cols_raw = pwdata[DIM_W-1:0];
                end else begin
                    rows_raw = pwdata[DIM_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                take_cell(s_tdata[DATA_W-1:0], s_tdata[DATA_W +: DATA_W]);
            end
            if (end_of_run && !leftover_done) begin
                leftover_done = 1'b1;
                if (expected_cells.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_cells.size()));
                end
            end
        end
        fail_count      <= errors;
        pending         <= expected_cells.size();
        results_checked <= checked;
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// top of the five-point heat stencil testbench: clock, reset, grid stimulus and verdict
module testbench;
    import hsfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 100;

    typedef enum int {
        FILL_SMOOTH,
        FILL_WILD,
        FILL_EDGE,
        FILL_MAX,
        FILL_MIN,
        FILL_TABLE
    } fill_t;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_tvalid   = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata    = '0;
    logic                m_tvalid;
    logic                m_tready   = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                end_of_run = 1'b0;
    int                  fail_count;
    int                  pending;
    int                  results_checked;

    // padded-grid position as the block should track it
    int pad_row    = 0;
    int pad_col    = 0;
    int eff_cols   = 256;
    int eff_rows   = 256;
    int burst_left = 0;
    int items_sent = 0;
    int grids_sent = 0;
    int reg_writes = 0;
    int table_idx  = 0;
    int idle_cycles = 0;
    logic [63:0] ready_pat = '1;
    int pat_age = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    heat_stencil_five_point_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    heat_stencil_checker stencil_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .end_of_run      (end_of_run),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // receiver: a 64-bit ready pattern, reshuffled each time it runs out
    always @(posedge aclk) begin
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat = '1;
                1: ready_pat = {$urandom, $urandom};
                2: ready_pat = {$urandom, $urandom} & {$urandom, $urandom};
                default: ready_pat = {$urandom, $urandom} | {$urandom, $urandom};
            endcase
            ready_pat[0] = 1'b1;
        end
        m_tready <= ready_pat[pat_age];
        pat_age = (pat_age + 1) % 64;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        return (raw > DIM_W'(MAX_COLS)) ? MAX_COLS : int'(raw);
    endfunction

    function automatic logic [DATA_W-1:0] edge_value(input int k);
        case (k % 5)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] cell_value(input fill_t f);
        case (f)
            // about +-128.0 in q16.16, a plausible temperature field
            FILL_SMOOTH: return 32'($signed(24'($urandom)));
            FILL_WILD:   return $urandom;
            FILL_EDGE:   return $urandom_range(0, 1) ? edge_value($urandom_range(0, 4)) : $urandom;
            FILL_MAX:    return 32'h7FFF_FFFF;
            FILL_MIN:    return 32'h8000_0000;
            default: begin
                table_idx++;
                return edge_value(table_idx);
            end
        endcase
    endfunction

    function automatic fill_t pick_fill();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            return FILL_SMOOTH;
        end
        return (k < 8) ? FILL_WILD : FILL_EDGE;
    endfunction

    task automatic send_cell(input logic [DATA_W-1:0] old_v, input logic [DATA_W-1:0] prior_v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prior_v, old_v};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
        if (pad_col >= eff_cols + 1) begin
            pad_col = 0;
            if (pad_row >= eff_rows + 1) begin
                pad_row = 0;
                grids_sent++;
            end else begin
                pad_row++;
            end
        end else begin
            pad_col++;
        end
    endtask

    // streams cells until the position wraps back to the grid origin
    task automatic finish_grid(input fill_t f);
        do begin
            send_cell(cell_value(f), cell_value(f));
        end while (pad_row != 0 || pad_col != 0);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // halo cells may still sit in the pipe behind the last result
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRID_COLS) begin
            eff_cols = eff_dim(val);
        end else begin
            eff_rows = eff_dim(val);
        end
        reg_writes++;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
        wait_quiet();
        write_reg(REG_GRID_COLS, cols);
        write_reg(REG_GRID_ROWS, rows);
    endtask

    initial begin : stimulus
        int start_items;
        int split;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero in both registers gives the one-cell grid
        write_reg(REG_GRID_COLS, '0);
        write_reg(REG_GRID_ROWS, '0);
        finish_grid(FILL_MAX);
        finish_grid(FILL_MIN);
        finish_grid(FILL_TABLE);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            set_dims(($urandom_range(0, 9) == 0) ? DIM_W'(0) : DIM_W'($urandom_range(1, 8)),
                     ($urandom_range(0, 9) == 0) ? DIM_W'(0) : DIM_W'($urandom_range(1, 6)));
            repeat ($urandom_range(1, 3)) finish_grid(pick_fill());
        end

        // resize the grid to at most its current size while a sweep is under way, then let it wrap
        repeat (2) begin
            set_dims(DIM_W'($urandom_range(3, 6)), DIM_W'($urandom_range(2, 4)));
            split = $urandom_range(1, (eff_cols + 2) * (eff_rows + 2) - 1);
            repeat (split) send_cell(cell_value(FILL_SMOOTH), cell_value(FILL_SMOOTH));
            wait_quiet();
            write_reg(REG_GRID_COLS, DIM_W'($urandom_range(1, eff_cols)));
            write_reg(REG_GRID_ROWS, DIM_W'($urandom_range(1, eff_rows)));
            finish_grid(pick_fill());
        end

        // widest row, written above the maximum, then narrowed early in the next row
        set_dims(9'h1FF, 9'd1);
        repeat (MAX_COLS + 4) send_cell(cell_value(FILL_EDGE), cell_value(FILL_EDGE));
        wait_quiet();
        write_reg(REG_GRID_COLS, DIM_W'(2));
        finish_grid(FILL_EDGE);

        wait_quiet();
        repeat (4) @(posedge aclk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("swept %0d padded cells over %0d grids with %0d register writes",
                 items_sent, grids_sent, reg_writes);
        $display("compared %0d cell updates, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
